// File: src/edds_pkg.sv
`default_nettype none
package edds_pkg;

  localparam int unsigned RowStepW = 17;
  localparam logic [RowStepW-1:0] SmallRowStepRst = RowStepW'(4369);
  localparam logic [RowStepW-1:0] BigRowStepRst   = RowStepW'(4370);

  localparam logic CfgSmallRowStep = 1'b0;
  localparam logic CfgBigRowStep   = 1'b1;

  localparam logic OpSetup = 1'b0;
  localparam logic OpStep  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] x_top;
    logic signed [31:0] y_top;
    logic signed [31:0] x_bottom;
    logic signed [31:0] y_bottom;
    logic signed [31:0] y_start;
    logic signed [31:0] step_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] edge_x;
    logic signed [63:0] error_term;
    logic signed [31:0] small_step_x;
    logic signed [31:0] small_step_frac;
    logic signed [31:0] big_step_x;
    logic signed [31:0] big_step_frac;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

  function automatic logic [63:0] sext64(input logic [31:0] v);
    sext64 = {{32{v[31]}}, v};
  endfunction

  function automatic logic [32:0] sext33(input logic [31:0] v);
    sext33 = {v[31], v};
  endfunction

endpackage
`default_nettype wire

// File: src/edds_div.sv
`default_nettype none
module edds_div
  import edds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy_r, busy_nxt;
  logic        fin_r, fin_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic        qneg_r, qneg_nxt;
  logic        rneg_r, rneg_nxt;
  logic        done_r;
  logic [63:0] quot_r, remo_r;
  logic [64:0] trial;

  assign trial = {rem_r, dvd_r[63]} - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend[63] ? (64'd0 - req.dividend) : req.dividend;
      dsr_nxt  = req.divisor[63] ? (64'd0 - req.divisor) : req.divisor;
      qneg_nxt = req.dividend[63] ^ req.divisor[63];
      rneg_nxt = req.dividend[63];
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        dvd_nxt = {dvd_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], dvd_r[63]};
        dvd_nxt = {dvd_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
    if (fin_r) begin
      quot_r <= qneg_r ? (64'd0 - dvd_r) : dvd_r;
      remo_r <= rneg_r ? (64'd0 - rem_r) : rem_r;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = remo_r;

endmodule
`default_nettype wire

// File: src/edds_mul.sv
`default_nettype none
module edds_mul
  import edds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic [63:0]             prod_r
);

  logic signed [65:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    prod_r <= full[63:0];
  end

endmodule
`default_nettype wire

// File: src/edge_dda_setup_and_step.sv
`default_nettype none
// Edge DDA stepper, 16.16 fixed point.
// Input channel (in_valid/in_stall, payload in_data): opcode 0 sets up an
// edge from its endpoints and steps it to y_start; opcode 1 steps the held
// edge by step_count. Each transfer yields exactly one result on the output
// channel (out_valid/out_stall, payload out_data): edge x, error term and the
// small and big multi-row increments.
// Configuration: cfg_we writes cfg_wdata into the small (index 0) or big
// (index 1) row step; write only while no item is in flight.
// All work runs on one shared 64-bit restoring divider (one quotient bit
// per cycle) and one registered multiplier. A step item carries at most one
// division; a set-up item takes up to four divisions.
// One item is in work at a time; in_stall is high until it has finished.
// A finished result waits in the output register while out_stall is high,
// and the next item may be taken meanwhile.
// Reset: synchronous, active low; edge state clears to zero, row steps go
// to 4369 and 4370.
module edge_dda_setup_and_step
  import edds_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_addr,
  input  wire logic [RowStepW-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SETUP, ST_SDIV,
    ST_M_MUL_W, ST_M_MUL_F, ST_M_CHK, ST_M_DIV, ST_M_MUL_Q, ST_M_ADJ, ST_M_STORE,
    ST_E_MUL_W, ST_E_MUL_F, ST_E_SUM, ST_E_CHK, ST_E_DIV, ST_E_MUL_Q, ST_E_ADJ,
    ST_OUT
  } state_t;

  state_t state_r;

  logic [RowStepW-1:0] small_row_step_r, big_row_step_r;
  logic [31:0] pos_r, frac_r, height_r, whole_r;
  logic [63:0] err_r;
  logic        dir_r;
  logic [31:0] sw_r, sf_r, bw_r, bf_r;
  logic [31:0] dx_r, stepn_r, stepx_r, q_r;
  logic [63:0] ne_r;
  logic        sel_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  div_req_t     dreq;
  div_rsp_t     drsp;
  logic signed [32:0] mul_a, mul_b;
  logic [63:0]  prod;
  logic [RowStepW-1:0] rows;
  logic [63:0]  dy64;
  logic         out_free;

  edds_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  edds_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod));

  assign rows     = sel_r ? big_row_step_r : small_row_step_r;
  assign dy64     = sext64(height_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = dy64;
    unique case (state_r)
      ST_SETUP: begin
        dreq.start    = (height_r != 32'd0);
        dreq.dividend = dx_r[31] ? (64'd0 - sext64(dx_r)) : sext64(dx_r);
      end
      ST_M_MUL_W: begin
        mul_a = {16'd0, rows};
        mul_b = sext33(whole_r);
      end
      ST_M_MUL_F: begin
        mul_a = {16'd0, rows};
        mul_b = sext33(frac_r);
      end
      ST_M_CHK: begin
        dreq.start    = !prod[63] && (prod != 64'd0);
        dreq.dividend = prod;
      end
      ST_M_MUL_Q, ST_E_MUL_Q: begin
        mul_a = sext33(q_r);
        mul_b = sext33(height_r);
      end
      ST_E_MUL_W: begin
        mul_a = sext33(stepn_r);
        mul_b = sext33(whole_r);
      end
      ST_E_MUL_F: begin
        mul_a = sext33(stepn_r);
        mul_b = sext33(frac_r);
      end
      ST_E_CHK: begin
        if (height_r != 32'd0) begin
          if (!stepn_r[31]) begin
            dreq.start    = !ne_r[63] && (ne_r != 64'd0);
            dreq.dividend = ne_r + dy64 - 64'd1;
          end else begin
            dreq.start    = $signed(ne_r) <= -$signed(dy64);
            dreq.dividend = 64'd0 - ne_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      small_row_step_r <= SmallRowStepRst;
      big_row_step_r   <= BigRowStepRst;
      pos_r    <= '0;
      err_r    <= '0;
      frac_r   <= '0;
      height_r <= '0;
      whole_r  <= '0;
      dir_r    <= 1'b0;
      sw_r     <= '0;
      sf_r     <= '0;
      bw_r     <= '0;
      bf_r     <= '0;
      sel_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CfgSmallRowStep: small_row_step_r <= cfg_wdata;
          CfgBigRowStep:   big_row_step_r   <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.opcode == OpSetup) begin
              dx_r     <= in_data.x_bottom - in_data.x_top;
              height_r <= in_data.y_bottom - in_data.y_top;
              pos_r    <= in_data.x_top;
              err_r    <= '0;
              frac_r   <= '0;
              whole_r  <= '0;
              dir_r    <= 1'b0;
              sw_r     <= '0;
              sf_r     <= '0;
              bw_r     <= '0;
              bf_r     <= '0;
              stepn_r  <= in_data.y_start - in_data.y_top;
              state_r  <= ST_SETUP;
            end else begin
              stepn_r <= in_data.step_count;
              state_r <= ST_E_MUL_W;
            end
          end
        end
        ST_SETUP: begin
          state_r <= (height_r != 32'd0) ? ST_SDIV : ST_E_MUL_W;
        end
        ST_SDIV: begin
          if (drsp.done) begin
            whole_r <= dx_r[31] ? (32'd0 - drsp.quot[31:0]) : drsp.quot[31:0];
            frac_r  <= drsp.rem[31:0];
            err_r   <= dx_r[31] ? 64'd0 : (64'd0 - dy64);
            dir_r   <= dx_r[31];
            sel_r   <= 1'b0;
            state_r <= ST_M_MUL_W;
          end
        end
        ST_M_MUL_W: state_r <= ST_M_MUL_F;
        ST_M_MUL_F: begin
          stepx_r <= prod[31:0];
          state_r <= ST_M_CHK;
        end
        ST_M_CHK: begin
          ne_r    <= prod;
          state_r <= dreq.start ? ST_M_DIV : ST_M_STORE;
        end
        ST_M_DIV: begin
          if (drsp.done) begin
            q_r     <= drsp.quot[31:0];
            state_r <= ST_M_MUL_Q;
          end
        end
        ST_M_MUL_Q: state_r <= ST_M_ADJ;
        ST_M_ADJ: begin
          ne_r    <= ne_r - prod;
          stepx_r <= stepx_r + (dir_r ? (32'd0 - q_r) : q_r);
          state_r <= ST_M_STORE;
        end
        ST_M_STORE: begin
          if (!sel_r) begin
            sw_r    <= stepx_r;
            sf_r    <= ne_r[31:0];
            sel_r   <= 1'b1;
            state_r <= ST_M_MUL_W;
          end else begin
            bw_r    <= stepx_r;
            bf_r    <= ne_r[31:0];
            state_r <= ST_E_MUL_W;
          end
        end
        ST_E_MUL_W: state_r <= ST_E_MUL_F;
        ST_E_MUL_F: begin
          pos_r   <= pos_r + prod[31:0];
          state_r <= ST_E_SUM;
        end
        ST_E_SUM: begin
          ne_r    <= err_r + prod;
          state_r <= ST_E_CHK;
        end
        ST_E_CHK: begin
          if (dreq.start) begin
            state_r <= ST_E_DIV;
          end else begin
            err_r   <= ne_r;
            state_r <= ST_OUT;
          end
        end
        ST_E_DIV: begin
          if (drsp.done) begin
            q_r     <= drsp.quot[31:0];
            state_r <= ST_E_MUL_Q;
          end
        end
        ST_E_MUL_Q: state_r <= ST_E_ADJ;
        ST_E_ADJ: begin
          if (!stepn_r[31]) begin
            err_r <= ne_r - prod;
            pos_r <= pos_r + (dir_r ? (32'd0 - q_r) : q_r);
          end else begin
            err_r <= ne_r + prod;
            pos_r <= pos_r + (dir_r ? q_r : (32'd0 - q_r));
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (state_r == ST_OUT && out_free) begin
      out_data_r.edge_x          <= pos_r;
      out_data_r.error_term      <= err_r;
      out_data_r.small_step_x    <= sw_r;
      out_data_r.small_step_frac <= sf_r;
      out_data_r.big_step_x      <= bw_r;
      out_data_r.big_step_frac   <= bf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top;
  import edds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam logic [31:0] SMin = 32'h8000_0000;
  localparam logic [31:0] SMax = 32'h7fff_ffff;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic                cfg_addr = CfgSmallRowStep;
  logic [RowStepW-1:0] cfg_wdata = '0;

  edge_dda_setup_and_step u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // edge state mirror
  logic [31:0] row_small = 32'd4369;
  logic [31:0] row_big   = 32'd4370;
  logic [31:0] e_pos = '0, e_frac = '0, e_dy = '0, e_whole = '0;
  logic [63:0] e_err = '0;
  logic        e_neg = 1'b0;
  logic [31:0] e_sw = '0, e_sf = '0, e_bw = '0, e_bf = '0;

  in_item_t  pend_q[$];
  out_item_t edge_exp_q[$];
  int        idle_pct = 0, stall_pct = 0;
  logic      snd_hold = 1'b0, rcv_hold = 1'b0;
  int        errors = 0, n_results = 0, n_setup = 0, n_step = 0, n_cfg = 0;
  int unsigned cycles = 0;

  function automatic longint sdiv(longint a, longint b);
    if (b == -1) return -a;
    return a / b;
  endfunction

  function automatic void row_incr(input logic [31:0] n, output logic [31:0] wh,
                                   output logic [31:0] fr);
    longint sdy, ne;
    logic [31:0] stepx, q;
    sdy = longint'($signed(e_dy));
    ne = longint'(n) * longint'($signed(e_frac));
    stepx = n * e_whole;
    if (ne > 0) begin
      q = 32'(ne / sdy);
      ne = ne - longint'($signed(q)) * sdy;
      stepx = e_neg ? stepx - q : stepx + q;
    end
    fr = 32'(ne);
    wh = stepx;
  endfunction

  function automatic void advance_edge(input logic [31:0] n);
    longint ne, dy;
    logic [31:0] q;
    e_pos = e_pos + n * e_whole;
    ne = longint'(e_err) + longint'($signed(n)) * longint'($signed(e_frac));
    if (e_dy == 0) begin
      e_err = ne;
      return;
    end
    dy = longint'($signed(e_dy));
    if (!n[31]) begin
      if (ne > 0) begin
        q = 32'(sdiv(ne + dy - 1, dy));
        ne = ne - longint'($signed(q)) * dy;
        e_pos = e_neg ? e_pos - q : e_pos + q;
      end
    end else if (ne <= -dy) begin
      q = 32'(sdiv(-ne, dy));
      ne = ne + longint'($signed(q)) * dy;
      e_pos = e_neg ? e_pos + q : e_pos - q;
    end
    e_err = ne;
  endfunction

  function automatic out_item_t edge_predict(in_item_t it);
    out_item_t r;
    logic [31:0] dxw, dyw;
    longint sdx, sdy;
    if (it.opcode == OpSetup) begin
      dxw = it.x_bottom - it.x_top;
      dyw = it.y_bottom - it.y_top;
      e_pos = it.x_top;
      e_err = '0;
      e_dy = dyw;
      e_frac = '0;
      e_whole = '0;
      e_neg = 1'b0;
      e_sw = '0; e_sf = '0; e_bw = '0; e_bf = '0;
      if (dyw != 0) begin
        sdx = longint'($signed(dxw));
        sdy = longint'($signed(dyw));
        if (sdx >= 0) begin
          e_whole = 32'(sdx / sdy);
          e_frac = 32'(sdx % sdy);
          e_err = -sdy;
        end else begin
          e_neg = 1'b1;
          e_whole = 32'(-((-sdx) / sdy));
          e_frac = 32'((-sdx) % sdy);
        end
        row_incr(row_small, e_sw, e_sf);
        row_incr(row_big, e_bw, e_bf);
      end
      advance_edge(it.y_start - it.y_top);
    end else begin
      advance_edge(it.step_count);
    end
    r.edge_x = e_pos;
    r.error_term = e_err;
    r.small_step_x = e_sw;
    r.small_step_frac = e_sf;
    r.big_step_x = e_bw;
    r.big_step_frac = e_bf;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        edge_exp_q.push_back(edge_predict(in_data));
        if (in_data.opcode == OpSetup) n_setup++;
        else n_step++;
      end
      if (pend_q.size() != 0 && !snd_hold && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t ex;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (edge_exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        ex = edge_exp_q.pop_front();
        if (ex !== out_data) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp x=%h err=%h sx=%h sf=%h bx=%h bf=%h | got x=%h err=%h sx=%h sf=%h bx=%h bf=%h",
                     ex.edge_x, ex.error_term, ex.small_step_x, ex.small_step_frac,
                     ex.big_step_x, ex.big_step_frac, out_data.edge_x, out_data.error_term,
                     out_data.small_step_x, out_data.small_step_frac, out_data.big_step_x,
                     out_data.big_step_frac);
        end
      end
    end
    out_stall <= rcv_hold || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] rnd32();
    case ($urandom_range(6))
      0, 1: return $urandom;
      2: return $urandom_range(1 << 20) - (1 << 19);
      3: return SMin;
      4: return SMax;
      5: return ($urandom_range(2000) - 1000) << 16;
      default: return $urandom_range(1) ? 32'hffff_ffff : 32'h0;
    endcase
  endfunction

  task automatic add_setup(logic [31:0] xt, logic [31:0] yt, logic [31:0] xb,
                           logic [31:0] yb, logic [31:0] ys);
    in_item_t it;
    it.opcode = OpSetup;
    it.x_top = xt; it.y_top = yt; it.x_bottom = xb; it.y_bottom = yb;
    it.y_start = ys;
    it.step_count = $urandom;
    pend_q.push_back(it);
  endtask

  task automatic add_step(logic [31:0] n);
    in_item_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.opcode = OpStep;
    it.step_count = n;
    pend_q.push_back(it);
  endtask

  task automatic add_random_edges(int count);
    int k;
    logic [31:0] yt, yb, xt;
    for (int i = 0; i < count; ) begin
      if ($urandom_range(9) == 0) begin
        add_step(rnd32());
        i++;
        continue;
      end
      xt = rnd32();
      yt = rnd32();
      case ($urandom_range(5))
        0: yb = yt;
        1: yb = yt + ($urandom_range(1) ? 32'd1 : 32'hffff_ffff);
        2: yb = rnd32();
        default: yb = yt + ($urandom_range(1 << 22) - (1 << 20));
      endcase
      add_setup(xt, yt, $urandom_range(2) == 0 ? rnd32()
                : xt + ($urandom_range(1 << 24) - (1 << 23)),
                yb, $urandom_range(1) ? rnd32() : yt + $urandom_range(1 << 18));
      i++;
      k = $urandom_range(8);
      for (int j = 0; j < k; j++) begin
        case ($urandom_range(4))
          0: add_step(rnd32());
          1: add_step(-$urandom_range(1 << 18));
          default: add_step($urandom_range(1 << 18));
        endcase
        i++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || edge_exp_q.size() != 0 || in_valid) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v[RowStepW-1:0];
    if (idx == CfgSmallRowStep) row_small = {15'b0, v[RowStepW-1:0]};
    else row_big = {15'b0, v[RowStepW-1:0]};
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] s_tab[8], b_tab[8];
    s_tab = '{4369, 1, 65536, 0, 131071, 1, 65536, 0};
    b_tab = '{4370, 65536, 1, 131071, 0, 1, 65536, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: typical, negative slope, flat, upward, wrap and overflow corners
    add_setup(0, 0, 10 << 16, 20 << 16, 5 << 16);
    add_step(65536);
    add_step(-3 * 65536);
    add_step(0);
    add_setup(100 << 16, 0, -50 << 16, 7 << 16, 0);
    add_step(1 << 20);
    add_step(-(1 << 20));
    add_setup(3 << 16, 9 << 16, 40 << 16, 9 << 16, (9 << 16) + 12345);
    add_step(70000);
    add_step(-70000);
    add_setup(5 << 16, 10 << 16, 1 << 16, 0, 3 << 16);
    add_step(12345);
    add_step(-99999);
    add_setup(SMin, SMin, SMax, SMax, 0);
    add_step(SMin);
    add_step(SMax);
    add_setup(SMax, 0, SMin, 1, SMax);
    add_setup(0, 1, SMin, 0, SMin);
    add_step(32'hffff_ffff);
    add_step(1);
    add_setup(0, 0, 1, 32'h7fff_0000, 32'h4000_0000);
    add_step(SMin);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      if (ph != 0) begin
        write_reg(CfgSmallRowStep, s_tab[ph] == 0 && ph == 7 ? $urandom_range(1, 65536)
                  : s_tab[ph]);
        write_reg(CfgBigRowStep, b_tab[ph] == 0 && ph == 7 ? $urandom_range(1, 65536)
                  : b_tab[ph]);
      end
      idle_pct <= (ph % 4 == 1) ? 87 : (ph % 4 == 3) ? 10 : 0;
      stall_pct <= (ph % 4 == 2) ? 87 : (ph % 4 == 3) ? 10 : 0;
      add_random_edges(135);
      if (ph == 2) begin
        fork
          begin
            @(posedge clk);
            rcv_hold <= 1'b1;
            repeat (3000) @(posedge clk);
            rcv_hold <= 1'b0;
          end
        join_none
      end
      if (ph == 5) begin
        while (pend_q.size() > 60) @(posedge clk);
        snd_hold <= 1'b1;
        @(posedge clk);
        while (edge_exp_q.size() != 0 || in_valid) @(posedge clk);
        snd_hold <= 1'b0;
      end
    end
    wait_drained();
    repeat (400) @(posedge clk);
    if (edge_exp_q.size() != 0) errors += edge_exp_q.size();
    $display("covered %0d set-up and %0d step transfers, %0d results checked",
             n_setup, n_step, n_results);
    $display("%0d row-step writes over 8 phases of sender/receiver idling", n_cfg);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
